### src/scsa_pkg.sv
// -----------------------------------------------------------------------------
// scsa_pkg
// Types, codes and helpers shared by the size-class slab allocator modules.
// -----------------------------------------------------------------------------
package scsa_pkg;

  localparam int ADDR_W      = 18;
  localparam int REQ_W       = 16;
  localparam int PAGE_BYTES  = 4096;
  localparam int PAGE_OFF_W  = 12;
  localparam int OFF_W       = PAGE_OFF_W + 1;
  localparam int MAX_CLASSES = 8;
  localparam int CLS_W       = 3;
  localparam int MIN_BLOCK   = 8;
  localparam int WORD_SHIFT  = 3;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_FREED     = 3'd1,
    ST_OOM       = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_NULL      = 3'd4,
    ST_REJECTED  = 3'd5
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_CSTART,
    S_CARVE,
    S_POP,
    S_OWN,
    S_FREE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } res_t;

  typedef struct packed {
    logic             found;
    logic [CLS_W-1:0] cls;
  } fit_t;

  // First class whose block size (8 << c) covers the request.
  function automatic fit_t class_fit(logic [REQ_W-1:0] req, int num_classes);
    fit_t f;
    f = '0;
    for (int c = MAX_CLASSES - 1; c >= 0; c--) begin
      if (c < num_classes && ((17'(MIN_BLOCK) << c) >= {1'b0, req})) begin
        f.found = 1'b1;
        f.cls   = CLS_W'(c);
      end
    end
    return f;
  endfunction

endpackage

### src/scsa_ram.sv
// -----------------------------------------------------------------------------
// scsa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// -----------------------------------------------------------------------------
module scsa_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/scsa_ctrl.sv
// -----------------------------------------------------------------------------
// scsa_ctrl
// Sequencer of the allocator: list heads, page carving with one shared offset
// adder, and the read-modify-write steps on the link and owner memories.
// -----------------------------------------------------------------------------
module scsa_ctrl
  import scsa_pkg::*;
#(
  parameter int NUM_PAGES   = 64,
  parameter int NUM_CLASSES = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [REQ_W-1:0]                 in_req,
  input  logic [ADDR_W-1:0]                in_addr,
  input  logic                             out_ready,
  output logic                             done,
  output res_t                             res,
  output logic                             link_we,
  output logic [$clog2(NUM_PAGES*512)-1:0] link_waddr,
  output logic [ADDR_W-1:0]                link_wdata,
  output logic [$clog2(NUM_PAGES*512)-1:0] link_raddr,
  input  logic [ADDR_W-1:0]                link_rdata,
  output logic                             own_we,
  output logic [$clog2(NUM_PAGES)-1:0]     own_waddr,
  output logic [CLS_W-1:0]                 own_wdata,
  output logic [$clog2(NUM_PAGES)-1:0]     own_raddr,
  input  logic [CLS_W-1:0]                 own_rdata
);

  localparam int LINK_AW = $clog2(NUM_PAGES * 512);
  localparam int OWN_AW  = $clog2(NUM_PAGES);
  localparam int PG_W    = $clog2(NUM_PAGES + 1);
  localparam int PAGE_W  = ADDR_W - PAGE_OFF_W;

  state_t              state, state_next;
  logic                booting;
  logic [CLS_W-1:0]    cls;
  logic [ADDR_W-1:0]   addr_q;
  logic [PG_W-1:0]     next_page;
  logic [OFF_W-1:0]    off;
  logic [ADDR_W-1:0]   head [MAX_CLASSES];
  logic [ADDR_W-1:0]   res_addr;
  status_t             res_status;

  logic [OFF_W-1:0]    blk_size;
  logic [OFF_W-1:0]    off_sum;
  logic                carve_last;
  logic [ADDR_W-1:0]   carve_addr;
  logic [ADDR_W-1:0]   carve_link;
  logic [ADDR_W-1:0]   carve_first;
  logic [ADDR_W-1:0]   cur_head;
  logic [PAGE_W-1:0]   in_page;
  logic                in_reject;
  logic                accept;
  fit_t                fit;

  assign blk_size    = OFF_W'(MIN_BLOCK) << cls;
  // The shared adder walks the carve offset one block at a time.
  assign off_sum     = off + blk_size;
  assign carve_last  = off_sum[OFF_W-1];
  assign carve_addr  = ADDR_W'({next_page, off[PAGE_OFF_W-1:0]});
  assign carve_link  = carve_last ? '0 : ADDR_W'({next_page, off_sum[PAGE_OFF_W-1:0]});
  assign carve_first = ADDR_W'({next_page, blk_size[PAGE_OFF_W-1:0]});
  assign cur_head    = head[cls];
  assign in_page     = in_addr[ADDR_W-1:PAGE_OFF_W];
  assign in_reject   = (in_addr[PAGE_OFF_W-1:0] == '0) || (int'(in_page) >= int'(next_page))
                       || (int'(in_page) >= NUM_PAGES);
  assign accept      = in_valid && in_ready;
  assign fit         = class_fit(in_req, NUM_CLASSES);

  assign res.addr    = res_addr;
  assign res.status  = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    done       = 1'b0;
    link_we    = 1'b0;
    link_waddr = LINK_AW'(carve_addr[ADDR_W-1:WORD_SHIFT]);
    link_wdata = carve_link;
    link_raddr = LINK_AW'(cur_head[ADDR_W-1:WORD_SHIFT]);
    own_we     = 1'b0;
    own_waddr  = OWN_AW'(next_page);
    own_wdata  = cls;
    own_raddr  = OWN_AW'(in_page);
    case (state)
      S_INIT: begin
        state_next = (int'(next_page) == NUM_CLASSES) ? S_IDLE : S_CSTART;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_ALLOC) begin
            state_next = fit.found ? S_ALLOC : S_DONE;
          end else if (in_addr == '0 || in_reject) begin
            state_next = S_DONE;
          end else begin
            state_next = S_OWN;
          end
        end
      end
      S_ALLOC: begin
        if (cur_head != '0) begin
          state_next = S_POP;
        end else if (int'(next_page) < NUM_PAGES) begin
          state_next = S_CSTART;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CSTART: begin
        state_next = S_CARVE;
      end
      S_CARVE: begin
        link_we = 1'b1;
        if (carve_last) begin
          own_we     = 1'b1;
          state_next = booting ? S_INIT : S_ALLOC;
        end
      end
      S_POP: begin
        state_next = S_DONE;
      end
      S_OWN: begin
        state_next = S_FREE;
      end
      S_FREE: begin
        link_we    = 1'b1;
        link_waddr = LINK_AW'(addr_q[ADDR_W-1:WORD_SHIFT]);
        link_wdata = cur_head;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_ready) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      booting   <= 1'b1;
      next_page <= '0;
    end else begin
      if (state == S_INIT && int'(next_page) == NUM_CLASSES) begin
        booting <= 1'b0;
      end
      if (state == S_CARVE && carve_last) begin
        next_page <= next_page + PG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_INIT: begin
        cls <= CLS_W'(next_page);
      end
      S_IDLE: begin
        if (accept) begin
          addr_q   <= in_addr;
          cls      <= fit.cls;
          res_addr <= '0;
          if (in_op == OP_ALLOC) begin
            res_status <= ST_TOO_LARGE;
          end else if (in_addr == '0) begin
            res_status <= ST_NULL;
          end else begin
            res_status <= ST_REJECTED;
          end
        end
      end
      S_ALLOC: begin
        if (cur_head == '0) begin
          res_status <= ST_OOM;
        end
      end
      S_CSTART: begin
        off <= blk_size;
      end
      S_CARVE: begin
        off <= off_sum;
        if (carve_last) begin
          head[cls] <= carve_first;
        end
      end
      S_POP: begin
        head[cls]  <= link_rdata;
        res_addr   <= cur_head;
        res_status <= ST_ALLOCATED;
      end
      S_OWN: begin
        cls <= (int'(own_rdata) >= NUM_CLASSES) ? '0 : own_rdata;
      end
      S_FREE: begin
        head[cls]  <= addr_q;
        res_status <= ST_FREED;
      end
      default: begin
      end
    endcase
  end

endmodule

### src/size_class_slab_allocator_top.sv
// -----------------------------------------------------------------------------
// size_class_slab_allocator_top
// Slab allocator over an arena of 4 KiB pages with eight size classes.
// -----------------------------------------------------------------------------
// Usage:
// An allocate or free request arrives as one beat on the s_axis channel; the
// opcode travels in s_axis_tuser. Each request yields exactly one beat on the
// m_axis channel carrying the block address and a status code in tuser.
// The block handles one request at a time and s_axis_tready is high only
// while it is idle. A pop from a non-empty list or a free is bounded by the
// registered read of the link or owner memory before the result beat.
// A too-large request or a rejected free goes straight to the result beat.
// An allocate that finds its list empty first carves a fresh page, writing
// one link word a cycle, and then pops a block from the new list.
// After reset the block carves a start-up page for every class in turn, with
// s_axis_tready held low. The result beat sits in an output register; a
// stalled receiver holds it, and the block may accept the next request
// meanwhile, finishing it once the output register frees.
// -----------------------------------------------------------------------------
module size_class_slab_allocator_top
  import scsa_pkg::*;
#(
  parameter int NUM_PAGES   = 64,
  parameter int NUM_CLASSES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [15:0] request_bytes, [33:16] block_address
  input  logic        s_axis_tuser,  // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [17:0] result_address
  output logic [2:0]  m_axis_tuser   // [2:0] status
);

  localparam int LINK_AW = $clog2(NUM_PAGES * 512);
  localparam int OWN_AW  = $clog2(NUM_PAGES);

  logic               done;
  logic               out_ready;
  res_t               res;
  res_t               out_q;
  logic               link_we;
  logic [LINK_AW-1:0] link_waddr;
  logic [ADDR_W-1:0]  link_wdata;
  logic [LINK_AW-1:0] link_raddr;
  logic [ADDR_W-1:0]  link_rdata;
  logic               own_we;
  logic [OWN_AW-1:0]  own_waddr;
  logic [CLS_W-1:0]   own_wdata;
  logic [OWN_AW-1:0]  own_raddr;
  logic [CLS_W-1:0]   own_rdata;

  assign out_ready = !m_axis_tvalid || m_axis_tready;

  scsa_ctrl #(
    .NUM_PAGES  (NUM_PAGES),
    .NUM_CLASSES(NUM_CLASSES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_req    (s_axis_tdata[REQ_W-1:0]),
    .in_addr   (s_axis_tdata[REQ_W+ADDR_W-1:REQ_W]),
    .out_ready (out_ready),
    .done      (done),
    .res       (res),
    .link_we   (link_we),
    .link_waddr(link_waddr),
    .link_wdata(link_wdata),
    .link_raddr(link_raddr),
    .link_rdata(link_rdata),
    .own_we    (own_we),
    .own_waddr (own_waddr),
    .own_wdata (own_wdata),
    .own_raddr (own_raddr),
    .own_rdata (own_rdata)
  );

  scsa_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(NUM_PAGES * 512)
  ) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .raddr(link_raddr),
    .rdata(link_rdata)
  );

  scsa_ram #(
    .WIDTH(CLS_W),
    .DEPTH(NUM_PAGES)
  ) u_owner_ram (
    .clk  (clk),
    .we   (own_we),
    .waddr(own_waddr),
    .wdata(own_wdata),
    .raddr(own_raddr),
    .rdata(own_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = {6'b0, out_q.addr};
  assign m_axis_tuser = out_q.status;

endmodule

### src/scsa_checker.sv
// -----------------------------------------------------------------------------
// scsa_checker
// Port-level checks on the allocator's request and result channels.
// -----------------------------------------------------------------------------
module scsa_checker
  import scsa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // A held result beat stays on the bus until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
    else $error("result beat dropped or changed while stalled");

  // Only one request is in flight, so ready drops after every accepted beat.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another was in progress");

  // Every outcome other than a successful allocate carries a null address.
  a_null_on_fail: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_ALLOCATED |-> m_axis_tdata == '0)
    else $error("non-null address on a failed or free result");

  // An allocated block never sits at the start of a page and padding is zero.
  a_alloc_addr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_ALLOCATED |->
      m_axis_tdata[11:0] != '0 && m_axis_tdata[23:18] == '0)
    else $error("allocated address points at a page header");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser != 3'd6 && m_axis_tuser != 3'd7)
    else $error("undefined status code on the result channel");

endmodule

bind size_class_slab_allocator_top scsa_checker u_scsa_checker (.*);
